[hdl/sha256_pkg.sv]
// sha256_pkg: shared types, constants and round functions for the sha-256 hasher
// no dependencies
package sha256_pkg;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef logic [31:0] word_t;

	localparam logic [7:0] PadMark = 8'h80;
	localparam logic [5:0] LenPos = 6'd56;

	localparam word_t InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t ssig0(input word_t x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

[hdl/sha256_in_if.sv]
// sha256_in_if: input channel carrying one byte and end mark per beat
// no dependencies
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

[hdl/sha256_out_if.sv]
// sha256_out_if: output channel carrying one digest word per beat
// no dependencies
interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[hdl/sha256_byte_stream_hasher.sv]
// sha256_byte_stream_hasher: sha-256 over a byte stream, one byte per input beat
// depends on sha256_pkg, sha256_in_if, sha256_out_if
// a byte that does not fill a block is stored in its schedule word; the 64th byte of a block
// triggers the rounds and then the fold on the single shared round unit
// end of message: pad sweep to byte 64 (one byte per cycle), one or two compressions,
// then eight output beats; arst_n loads the initial hash and clears counters
module sha256_byte_stream_hasher (
	input  logic         clk,
	input  logic         arst_n,
	sha256_in_if.sink    in_ch,
	sha256_out_if.source out_ch
);
	import sha256_pkg::*;

	state_t state_q, state_d;

	logic [5:0]  byte_idx_q;
	logic [63:0] msg_len_q;
	word_t       hash_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [5:0]  round_q;
	logic        final_q;
	logic        pad_done_q;
	logic        len_fits_q;
	logic        mark_q;
	logic [2:0]  out_idx_q;

	logic in_fire, out_fire, last_round, pad_last, load_block;
	logic [7:0] pad_byte;
	word_t w_cur, w_next, t1, t2;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign last_round = (round_q == 6'd63);
	assign pad_last = (byte_idx_q == 6'd63);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_fire) begin
					if (in_ch.byte_present && byte_idx_q == 6'd63)
						state_d = ST_ROUND;
					else if (in_ch.end_of_message)
						state_d = ST_PAD;
				end
			end
			ST_PAD:   if (pad_last) state_d = ST_ROUND;
			ST_ROUND: if (last_round) state_d = ST_FOLD;
			ST_FOLD: begin
				if (!final_q) state_d = ST_LOAD;
				else if (pad_done_q) state_d = ST_EMIT;
				else state_d = ST_PAD;
			end
			ST_EMIT: if (out_fire && out_idx_q == 3'd7) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ch.ready  = 1'b0;
		out_ch.valid = 1'b0;
		unique case (state_q)
			ST_LOAD: in_ch.ready  = 1'b1;
			ST_EMIT: out_ch.valid = 1'b1;
			default: ;
		endcase
	end

	assign out_ch.digest_word = hash_q[out_idx_q];
	assign out_ch.word_index  = out_idx_q;
	assign out_ch.last_word   = (out_idx_q == 3'd7);

	// pad byte for the current sweep position: mark, zeros or big-endian bit count
	always_comb begin
		pad_byte = 8'h00;
		if (mark_q)
			pad_byte = PadMark;
		else if (len_fits_q && byte_idx_q >= LenPos)
			pad_byte = msg_len_q[{~byte_idx_q[2:0], 3'b000} +: 8];
	end

	// shared round unit with a sliding 16-word schedule window
	assign w_cur  = w_q[0];
	assign w_next = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ RoundK[round_q] + w_cur;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign load_block = (state_q == ST_LOAD && in_fire && in_ch.byte_present
		&& byte_idx_q == 6'd63) || (state_q == ST_PAD && pad_last);

	// schedule window: bytes land in their word lane, rounds slide the window
	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_next;
		end else if (state_q == ST_LOAD && in_fire && in_ch.byte_present)
			w_q[byte_idx_q[5:2]][{~byte_idx_q[1:0], 3'b000} +: 8] <= in_ch.data_byte;
		else if (state_q == ST_PAD)
			w_q[byte_idx_q[5:2]][{~byte_idx_q[1:0], 3'b000} +: 8] <= pad_byte;
	end

	// working variables
	always_ff @(posedge clk) begin
		if (load_block) begin
			for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			byte_idx_q <= '0;
			msg_len_q  <= '0;
			round_q    <= '0;
			final_q    <= 1'b0;
			pad_done_q <= 1'b0;
			len_fits_q <= 1'b0;
			mark_q     <= 1'b0;
			out_idx_q  <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= InitH[i];
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (in_ch.byte_present) begin
							byte_idx_q <= byte_idx_q + 6'd1;
							msg_len_q  <= msg_len_q + 64'd8;
						end
						final_q <= in_ch.end_of_message;
						// mark byte goes in on the first pad cycle
						mark_q <= in_ch.end_of_message;
						pad_done_q <= 1'b0;
						round_q <= '0;
						// length fits unless the mark lands at or past the length field
						if (in_ch.end_of_message && !(in_ch.byte_present && byte_idx_q == 6'd63))
							len_fits_q <= (byte_idx_q + {5'd0, in_ch.byte_present}) < LenPos;
						else if (in_ch.end_of_message)
							len_fits_q <= 1'b1;
					end
				end
				ST_PAD: begin
					byte_idx_q <= byte_idx_q + 6'd1;
					mark_q <= 1'b0;
					if (pad_last) begin
						pad_done_q <= len_fits_q;
						round_q <= '0;
					end
				end
				ST_ROUND: round_q <= round_q + 6'd1;
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
					if (final_q && !pad_done_q) len_fits_q <= 1'b1;
				end
				ST_EMIT: begin
					if (out_fire) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							byte_idx_q <= '0;
							msg_len_q  <= '0;
							final_q    <= 1'b0;
							for (int i = 0; i < 8; i++) hash_q[i] <= InitH[i];
						end
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("input and output open together");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> !in_ch.ready)
		else $error("input taken during rounds");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && last_round) |=> state_q == ST_FOLD)
		else $error("fold missed after last round");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && out_ch.last_word) |=> (byte_idx_q == 6'd0 && msg_len_q == 64'd0))
		else $error("state not cleared after digest");

endmodule
